// ----- sv/cihcc_pkg.sv -----
// Shared types, constants and the CRC-16 byte update for the clip image checker.
// No dependencies; cihcc_regs and the top level import this package, cihcc_out_if uses its status type.
`timescale 1ns / 1ps

package cihcc_pkg;

  // Image layout
  localparam int HEADER_BYTES = 4096;
  localparam int POS_W        = $clog2(HEADER_BYTES);
  localparam int ENTRY_W      = POS_W - 4;

  localparam logic [POS_W-1:0] LAST_POS    = POS_W'(HEADER_BYTES - 1);
  localparam logic [POS_W-1:0] SYNC_END    = POS_W'(4);
  localparam logic [POS_W-1:0] CRCF_END    = POS_W'(8);
  localparam logic [POS_W-1:0] CRCF_LO     = POS_W'(4);
  localparam logic [POS_W-1:0] CRCF_HI     = POS_W'(5);
  localparam logic [POS_W-1:0] COUNT_POS   = POS_W'(8);
  localparam logic [POS_W-1:0] ENTRY_START = POS_W'(9);
  localparam logic [3:0]       SIZE_OFFSET = 4'd12;
  localparam logic [3:0]       ENTRY_LAST  = 4'd15;

  // CRC-16, MSB first
  localparam logic [15:0] CRC_POLY = 16'h1021;

  // Result status codes
  typedef logic [1:0] status_t;
  localparam status_t ST_CHECKED    = 2'd0;
  localparam status_t ST_NO_SYNC    = 2'd1;
  localparam status_t ST_OVER_LIMIT = 2'd2;

  // Register file
  localparam int          ADDR_W           = 3;
  localparam logic        REG_SYNC_WORD    = 1'b0;
  localparam logic        REG_DATA_LIMIT   = 1'b1;
  localparam logic [31:0] SYNC_WORD_RESET  = 32'h4255564D;
  localparam logic [31:0] DATA_LIMIT_RESET = 32'd847872;

  typedef struct packed {
    logic [31:0] sync_word;
    logic [31:0] data_limit;
  } cfg_t;

  // One byte through the CRC, eight shift steps
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ----- sv/cihcc_in_if.sv -----
// Input channel: one image byte per request with its start mark.
// Uses nothing from cihcc_pkg; carries plain vectors.
`timescale 1ns / 1ps

interface cihcc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       image_start;

  modport source (output valid, output data_byte, output image_start, input ready);
  modport sink   (input valid, input data_byte, input image_start, output ready);
endinterface

// ----- sv/cihcc_out_if.sv -----
// Result channel: status, CRCs, match flag and summed clip length.
// Depends on cihcc_pkg for the status type.
`timescale 1ns / 1ps

interface cihcc_out_if;
  logic                 valid;
  logic                 ready;
  cihcc_pkg::status_t   status;
  logic [15:0]          crc_value;
  logic [15:0]          stored_crc;
  logic                 crc_match;
  logic [31:0]          total_length;

  modport source (output valid, output status, output crc_value, output stored_crc,
                  output crc_match, output total_length, input ready);
  modport sink   (input valid, input status, input crc_value, input stored_crc,
                  input crc_match, input total_length, output ready);
endinterface

// ----- sv/cihcc_regs.sv -----
// APB register file: sync word and data length limit.
// Depends on cihcc_pkg for the address map, reset values and cfg_t.
`timescale 1ns / 1ps

module cihcc_regs (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [cihcc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output cihcc_pkg::cfg_t           cfg
);
  import cihcc_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // Write registers on the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sync_word  <= SYNC_WORD_RESET;
      cfg.data_limit <= DATA_LIMIT_RESET;
    end else if (wr_en) begin
      case (paddr[2])
        REG_SYNC_WORD:  cfg.sync_word  <= pwdata;
        REG_DATA_LIMIT: cfg.data_limit <= pwdata;
        default:        cfg.sync_word  <= cfg.sync_word;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (paddr[2])
      REG_SYNC_WORD:  prdata = cfg.sync_word;
      REG_DATA_LIMIT: prdata = cfg.data_limit;
      default:        prdata = 32'h0;
    endcase
  end

endmodule

// ----- sv/clip_image_header_crc_check.sv -----
// Clip image checker top level: header parse, CRC-16 and result register.
// Depends on cihcc_pkg, cihcc_in_if, cihcc_out_if and cihcc_regs.
//
//   port    dir   carries
//   in_ch   sink  data_byte, image_start (one image byte per request)
//   out_ch  src   status, crc_value, stored_crc, crc_match, total_length
//   APB     slv   sync_word (0x0), data_limit (0x4)
//
// One byte is taken every cycle while in_ch.ready is high; the header state, CRC
// and any result all load into their registers at the end of the accepting cycle.
// A result is given at the last header byte or at the last data byte.
// Input stalls only while a result waits and out_ch.ready is low.
// Synchronous active-high rst returns to idle, waiting for image_start.
`timescale 1ns / 1ps

module clip_image_header_crc_check (
  input  logic                         clk,
  input  logic                         rst,
  cihcc_in_if.sink                     in_ch,
  cihcc_out_if.source                  out_ch,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [cihcc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import cihcc_pkg::*;

  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_HEADER = 2'd1;
  localparam logic [1:0] PH_DATA   = 2'd2;

  cfg_t cfg;

  cihcc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Check state
  logic [1:0]       phase, phase_next;
  logic [POS_W-1:0] byte_position, byte_position_next;
  logic [15:0]      running_crc, running_crc_next;
  logic             sync_match, sync_match_next;
  logic [15:0]      crc_field, crc_field_next;
  logic [7:0]       clip_count, clip_count_next;
  logic [31:0]      size_assembly, size_assembly_next;
  logic [31:0]      size_total, size_total_next;
  logic [31:0]      data_remaining, data_remaining_next;

  // Result register
  logic             res_valid;
  status_t          res_status, res_status_next;
  logic [15:0]      res_crc, res_crc_next;
  logic [15:0]      res_stored, res_stored_next;
  logic             res_match, res_match_next;
  logic [31:0]      res_total, res_total_next;

  logic               accept;
  logic               emit;
  logic [POS_W-1:0]   q;
  logic [3:0]         off;
  logic [ENTRY_W-1:0] entry;
  logic [32:0]        sum;
  logic [7:0]         b;

  assign in_ch.ready = !res_valid || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign b           = in_ch.data_byte;

  // Entry offset of the byte in hand, taken from the position before it advances
  assign q     = (in_ch.image_start ? '0 : byte_position) - ENTRY_START;
  assign off   = q[3:0];
  assign entry = q[POS_W-1:4];

  // Next state for one accepted byte
  always_comb begin
    phase_next          = phase;
    byte_position_next  = byte_position;
    running_crc_next    = running_crc;
    sync_match_next     = sync_match;
    crc_field_next      = crc_field;
    clip_count_next     = clip_count;
    size_assembly_next  = size_assembly;
    size_total_next     = size_total;
    data_remaining_next = data_remaining;
    emit                = 1'b0;
    sum                 = 33'h0;
    res_status_next     = ST_CHECKED;
    res_crc_next        = 16'h0;
    res_stored_next     = 16'h0;
    res_match_next      = 1'b0;
    res_total_next      = 32'h0;

    // Restart on the start mark, whatever the phase
    if (in_ch.image_start) begin
      phase_next          = PH_HEADER;
      byte_position_next  = '0;
      running_crc_next    = 16'h0;
      sync_match_next     = 1'b1;
      crc_field_next      = 16'h0;
      clip_count_next     = 8'h0;
      size_assembly_next  = 32'h0;
      size_total_next     = 32'h0;
      data_remaining_next = 32'h0;
    end

    case (phase_next)
      PH_HEADER: begin
        if (byte_position_next < SYNC_END) begin
          if (cfg.sync_word[{byte_position_next[1:0], 3'b000} +: 8] != b) begin
            sync_match_next = 1'b0;
          end
          running_crc_next = crc_byte(running_crc_next, b);
        end else if (byte_position_next < CRCF_END) begin
          // Stored CRC field is left out of the CRC
          if (byte_position_next == CRCF_LO) begin
            crc_field_next[7:0] = b;
          end else if (byte_position_next == CRCF_HI) begin
            crc_field_next[15:8] = b;
          end
        end else begin
          running_crc_next = crc_byte(running_crc_next, b);
          if (byte_position_next == COUNT_POS) begin
            clip_count_next = b;
          end else if (off >= SIZE_OFFSET) begin
            size_assembly_next[{off[1:0], 3'b000} +: 8] = b;
            if (off == ENTRY_LAST && 32'(entry) < 32'(clip_count_next)) begin
              sum = {1'b0, size_total_next} + {1'b0, size_assembly_next};
              size_total_next = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            end
          end
        end

        // End of header: report or move on to the clip data
        if (byte_position_next == LAST_POS) begin
          byte_position_next = '0;
          if (!sync_match_next) begin
            emit            = 1'b1;
            res_status_next = ST_NO_SYNC;
          end else if (size_total_next > cfg.data_limit) begin
            emit            = 1'b1;
            res_status_next = ST_OVER_LIMIT;
            res_crc_next    = running_crc_next;
            res_stored_next = crc_field_next;
            res_total_next  = size_total_next;
          end else if (size_total_next == 32'h0) begin
            emit            = 1'b1;
            res_status_next = ST_CHECKED;
            res_crc_next    = running_crc_next;
            res_stored_next = crc_field_next;
            res_match_next  = (running_crc_next == crc_field_next);
            res_total_next  = size_total_next;
          end else begin
            data_remaining_next = size_total_next;
            phase_next          = PH_DATA;
          end
        end else begin
          byte_position_next = byte_position_next + 1'b1;
        end
      end
      PH_DATA: begin
        running_crc_next = crc_byte(running_crc_next, b);
        if (data_remaining_next != 32'h0) begin
          data_remaining_next = data_remaining_next - 32'd1;
        end
        if (data_remaining_next == 32'h0) begin
          emit            = 1'b1;
          res_status_next = ST_CHECKED;
          res_crc_next    = running_crc_next;
          res_stored_next = crc_field_next;
          res_match_next  = (running_crc_next == crc_field_next);
          res_total_next  = size_total_next;
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase

    if (emit) begin
      phase_next = PH_IDLE;
    end
  end

  // Advance check state on each accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      byte_position  <= '0;
      running_crc    <= 16'h0;
      sync_match     <= 1'b1;
      crc_field      <= 16'h0;
      clip_count     <= 8'h0;
      size_assembly  <= 32'h0;
      size_total     <= 32'h0;
      data_remaining <= 32'h0;
    end else if (accept) begin
      phase          <= phase_next;
      byte_position  <= byte_position_next;
      running_crc    <= running_crc_next;
      sync_match     <= sync_match_next;
      crc_field      <= crc_field_next;
      clip_count     <= clip_count_next;
      size_assembly  <= size_assembly_next;
      size_total     <= size_total_next;
      data_remaining <= data_remaining_next;
    end
  end

  // Hold a result until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept && emit) begin
      res_valid <= 1'b1;
    end else if (out_ch.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      res_status <= res_status_next;
      res_crc    <= res_crc_next;
      res_stored <= res_stored_next;
      res_match  <= res_match_next;
      res_total  <= res_total_next;
    end
  end

  assign out_ch.valid        = res_valid;
  assign out_ch.status       = res_status;
  assign out_ch.crc_value    = res_crc;
  assign out_ch.stored_crc   = res_stored;
  assign out_ch.crc_match    = res_match;
  assign out_ch.total_length = res_total;

endmodule
